>>> rtl/core/hsd_pkg.sv
// Shared types and constants for the heading steer duty block.
package hsd_pkg;

  localparam int AngleW = 15;
  localparam int DutyW  = 12;
  localparam int GainW  = 16;
  localparam int ErrW   = 17;
  localparam int CorrW  = 33;
  localparam int SumW   = 34;
  localparam int FracW  = 14;
  localparam int QW     = SumW - FracW;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic        [DutyW-1:0]  duty_t;
  typedef logic        [GainW-1:0]  gain_t;
  typedef logic signed [ErrW-1:0]   err_t;
  typedef logic signed [CorrW-1:0]  corr_t;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_BASE_LEFT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_RIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEER_GAIN = 2'd2;

  localparam duty_t DUTY_MAX        = 12'd4000;
  localparam duty_t BASE_DUTY_RESET = 12'd2000;
  localparam gain_t GAIN_RESET      = 16'd5120;

  // Heading constants in 1/64 degree
  localparam err_t HALF_TURN = 17'sd11520;
  localparam err_t FULL_TURN = 17'sd23040;
  localparam logic [ErrW-1:0] SMALL_ERR = 17'd192;
  localparam logic [ErrW-1:0] MID_ERR   = 17'd640;

  typedef struct packed {
    logic vld;
    err_t err;
  } err_word_t;

  typedef struct packed {
    logic  vld;
    corr_t corr;
  } corr_word_t;

endpackage

>>> rtl/core/hsd_in_if.sv
// Input channel: target heading and measured yaw word.
interface hsd_in_if import hsd_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t target_angle;
  angle_t current_yaw;

  modport source (output valid, output target_angle, output current_yaw, input ready);
  modport sink   (input valid, input target_angle, input current_yaw, output ready);
endinterface

>>> rtl/core/hsd_out_if.sv
// Output channel: left and right wheel duty word.
interface hsd_out_if import hsd_pkg::*; ();
  logic  valid;
  logic  ready;
  duty_t duty_left;
  duty_t duty_right;

  modport source (output valid, output duty_left, output duty_right, input ready);
  modport sink   (input valid, input duty_left, input duty_right, output ready);
endinterface

>>> rtl/core/hsd_err.sv
// Error stages: heading difference, then small-error scaling and 360 degree wrap.
module hsd_err import hsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  angle_t    target_i,
  input  angle_t    yaw_i,
  output logic      up_rdy_o,
  input  logic      down_rdy_i,
  output err_word_t err_o
);

  logic   s1_vld_q, s1_vld_d;
  err_t   s1_err_q, s1_err_d;
  logic   s1_pn_q, s1_pn_d;   // target positive, yaw negative
  logic   s1_np_q, s1_np_d;   // target negative, yaw positive
  logic   s2_vld_q, s2_vld_d;
  err_t   s2_err_q, s2_err_d;
  logic   s1_en, s2_en;
  angle_t yaw_adj;
  logic [ErrW-1:0] mag;
  err_t   scaled;

  assign s2_en    = !s2_vld_q || down_rdy_i;
  assign s1_en    = !s1_vld_q || s2_en;
  assign up_rdy_o = s1_en;

  // Stage 1: zero yaw counts as one LSB
  always_comb begin
    yaw_adj  = (yaw_i == '0) ? angle_t'(1) : yaw_i;
    s1_err_d = err_t'(target_i) - err_t'(yaw_adj);
    s1_pn_d  = !target_i[AngleW-1] && (target_i != '0) && yaw_adj[AngleW-1];
    s1_np_d  = target_i[AngleW-1] && !yaw_adj[AngleW-1];
    s1_vld_d = s1_en ? vld_i : s1_vld_q;
  end

  // Stage 2: scale, then wrap
  always_comb begin
    mag = s1_err_q[ErrW-1] ? ErrW'(-s1_err_q) : ErrW'(s1_err_q);
    if (mag < SMALL_ERR) begin
      scaled = (s1_err_q <<< 2) + s1_err_q;
    end else if (mag < MID_ERR) begin
      scaled = s1_err_q <<< 2;
    end else begin
      scaled = s1_err_q;
    end
    s2_err_d = scaled;
    if (s1_pn_q && (scaled > HALF_TURN)) begin
      s2_err_d = scaled - FULL_TURN;
    end else if (s1_np_q && (scaled < -HALF_TURN)) begin
      s2_err_d = scaled + FULL_TURN;
    end
    s2_vld_d = s2_en ? s1_vld_q : s2_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_err_q <= s1_err_d;
      s1_pn_q  <= s1_pn_d;
      s1_np_q  <= s1_np_d;
    end
    if (s2_en) begin
      s2_err_q <= s2_err_d;
    end
  end

  assign err_o.vld = s2_vld_q;
  assign err_o.err = s2_err_q;

endmodule

>>> rtl/core/hsd_mul.sv
// Multiply stage: scaled error times the unsigned Q2.14 steering gain.
module hsd_mul import hsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  err_word_t  err_i,
  input  gain_t      gain_i,
  output logic       up_rdy_o,
  input  logic       down_rdy_i,
  output corr_word_t corr_o
);

  logic  vld_q, vld_d;
  corr_t corr_q, corr_d;
  logic  en;
  logic signed [ErrW*2-1:0] prod;

  assign en       = !vld_q || down_rdy_i;
  assign up_rdy_o = en;

  always_comb begin
    prod   = err_i.err * $signed({1'b0, gain_i});
    corr_d = prod[CorrW-1:0];
    vld_d  = en ? err_i.vld : vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      corr_q <= corr_d;
    end
  end

  assign corr_o.vld  = vld_q;
  assign corr_o.corr = corr_q;

endmodule

>>> rtl/core/hsd_duty.sv
// Duty stage: left base minus, right base plus correction; floor, clamp and hold.
module hsd_duty import hsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  corr_word_t corr_i,
  input  duty_t      base_l_i,
  input  duty_t      base_r_i,
  output logic       up_rdy_o,
  output logic       vld_o,
  input  logic       down_rdy_i,
  output duty_t      duty_l_o,
  output duty_t      duty_r_o
);

  logic  vld_q, vld_d;
  duty_t duty_l_q, duty_l_d;
  duty_t duty_r_q, duty_r_d;
  logic  en;
  logic signed [SumW-1:0] sum_l, sum_r, corr_x;

  assign en       = !vld_q || down_rdy_i;
  assign up_rdy_o = en;

  function automatic duty_t floor_clamp(logic signed [SumW-1:0] num);
    logic signed [QW-1:0] q;
    q = QW'(num >>> FracW);   // arithmetic shift floors
    if (q[QW-1]) begin
      return '0;
    end else if (q > $signed({{(QW-DutyW){1'b0}}, DUTY_MAX})) begin
      return DUTY_MAX;
    end else begin
      return q[DutyW-1:0];
    end
  endfunction

  always_comb begin
    corr_x   = SumW'(corr_i.corr);
    sum_l    = $signed({{(SumW-DutyW-FracW){1'b0}}, base_l_i, {FracW{1'b0}}}) - corr_x;
    sum_r    = $signed({{(SumW-DutyW-FracW){1'b0}}, base_r_i, {FracW{1'b0}}}) + corr_x;
    duty_l_d = floor_clamp(sum_l);
    duty_r_d = floor_clamp(sum_r);
    vld_d    = en ? corr_i.vld : vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      duty_l_q <= duty_l_d;
      duty_r_q <= duty_r_d;
    end
  end

  assign vld_o    = vld_q;
  assign duty_l_o = duty_l_q;
  assign duty_r_o = duty_r_q;

endmodule

>>> rtl/core/heading_steer_duty.sv
// Top level of the proportional heading controller for two wheel duties.
//
//   channel  dir  word contents                      handshake
//   in_i     in   target_angle, current_yaw (s15)    valid/ready
//   out_o    out  duty_left, duty_right (u12)        valid/ready
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i   write enable only
//
// Four register stages: error, scale and wrap, multiply, duty and clamp.
// One word enters per cycle while out_o does not stall; each result leaves
// from the duty and clamp register. The single multiplier sits alone
// in its stage. Reset clears the stage valid bits and loads the default
// bases and gain. A stall on out_o holds each stage that is full and
// lets empty stages fill, so nothing is dropped or repeated.
module heading_steer_duty import hsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsd_in_if.sink              in_i,
  hsd_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // Configuration registers; the user must write them only while the pipe is empty, the block does not enforce it
  duty_t base_l_q, base_l_d;
  duty_t base_r_q, base_r_d;
  gain_t gain_q, gain_d;

  err_word_t  err_w;
  corr_word_t corr_w;
  logic       mul_rdy;
  logic       duty_rdy;

  always_comb begin
    base_l_d = base_l_q;
    base_r_d = base_r_q;
    gain_d   = gain_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_LEFT:  base_l_d = cfg_wdata_i[DutyW-1:0];
        CFG_BASE_RIGHT: base_r_d = cfg_wdata_i[DutyW-1:0];
        CFG_STEER_GAIN: gain_d   = cfg_wdata_i[GainW-1:0];
        default: ;      // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_l_q <= BASE_DUTY_RESET;
      base_r_q <= BASE_DUTY_RESET;
      gain_q   <= GAIN_RESET;
    end else begin
      base_l_q <= base_l_d;
      base_r_q <= base_r_d;
      gain_q   <= gain_d;
    end
  end

  // Stages one and two: heading error, scaling and wrap
  hsd_err u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (in_i.valid),
    .target_i   (in_i.target_angle),
    .yaw_i      (in_i.current_yaw),
    .up_rdy_o   (in_i.ready),
    .down_rdy_i (mul_rdy),
    .err_o      (err_w)
  );

  // Stage three: gain multiply
  hsd_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .err_i      (err_w),
    .gain_i     (gain_q),
    .up_rdy_o   (mul_rdy),
    .down_rdy_i (duty_rdy),
    .corr_o     (corr_w)
  );

  // Stage four: base plus or minus correction, floor, clamp; drives out_o
  hsd_duty u_duty (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .corr_i     (corr_w),
    .base_l_i   (base_l_q),
    .base_r_i   (base_r_q),
    .up_rdy_o   (duty_rdy),
    .vld_o      (out_o.valid),
    .down_rdy_i (out_o.ready),
    .duty_l_o   (out_o.duty_left),
    .duty_r_o   (out_o.duty_right)
  );

  // Clamp keeps both duties in range
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.duty_left <= DUTY_MAX) && (out_o.duty_right <= DUTY_MAX))
    else $error("duty out of range");

  // A stalled error word holds until the multiply stage takes it
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_w.vld && !mul_rdy |=> err_w.vld && $stable(err_w.err))
    else $error("error word lost under stall");

  // A stalled correction word holds until the duty stage takes it
  a_corr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corr_w.vld && !duty_rdy |=> corr_w.vld && $stable(corr_w.corr))
    else $error("correction word lost under stall");

  // With zero gain the duties are the clamped bases
  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corr_w.vld && duty_rdy && (gain_q == '0) && !cfg_we_i |=>
      out_o.valid &&
      (out_o.duty_left == ((base_l_q > DUTY_MAX) ? DUTY_MAX : base_l_q)) &&
      (out_o.duty_right == ((base_r_q > DUTY_MAX) ? DUTY_MAX : base_r_q)))
    else $error("zero gain does not pass bases");

endmodule
